// ----- rtl/core/bpsr_pkg.sv -----
package bpsr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NUM_CORNERS  = 8;
  localparam int CORNER_IDX_W = $clog2(NUM_CORNERS);
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;

  typedef enum logic [1:0] {
    REG_ROW_ZERO  = 2'd0,
    REG_ROW_ONE   = 2'd1,
    REG_ROW_TWO   = 2'd2,
    REG_ROW_THREE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic first;
    logic last;
    logic zw;
    logic negx;
    logic negy;
    logic ovfx;
    logic ovfy;
  } corner_meta_t;

endpackage

// ----- rtl/core/box_projected_screen_rect_unit.sv -----
// Channel  | Signals                         | Request
// ---------+---------------------------------+---------------------------------------
// s (in)   | s_tvalid s_tready s_tdata       | box: center x,y,z then extent x,y,z
// m (out)  | m_tvalid m_tready m_tdata/tuser | rectangle left,right,top,bottom + flags
// cfg      | psel penable pwrite paddr ...   | matrix rows 0..3 at byte address 8*i
//
// A box's eight corners enter the pipeline one per cycle while m is not stalled, set by the
// single corner multiplier bank; the divider pipeline produces one quotient bit per stage.
// Synchronous active-high reset clears valid bits and the matrix to identity.
// A stall on m holds the whole pipeline; nothing is lost or repeated.
module box_projected_screen_rect_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // center_x, center_y, center_z, extent_x, extent_y, extent_z
  input  logic [((6*COORD_WIDTH-3+7)/8)*8-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // left_edge, right_edge, top_edge, bottom_edge
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
  // zero_w_seen, none_usable, saturated
  output logic [2:0]                            m_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bpsr_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [bpsr_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [bpsr_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int CW  = COORD_WIDTH;
  localparam int KW  = COEF_WIDTH;
  localparam int PW  = CW + 1;
  localparam int MW  = KW + PW;
  localparam int SW  = MW + 2;
  localparam int NW  = SW + bpsr_pkg::FRAC_BITS;
  localparam int HW  = NW - CW;
  localparam int OW  = ((4*CW+7)/8)*8;
  localparam int DW  = bpsr_pkg::CFG_DATA_W;
  localparam int XW  = bpsr_pkg::CORNER_IDX_W;
  localparam logic [XW-1:0] LAST_CORNER = XW'(bpsr_pkg::NUM_CORNERS - 1);

  function automatic logic [DW-1:0] ident_row(input int r);
    logic [DW-1:0] v;
    v = '0;
    v[r*KW + KW - 4] = 1'b1;
    return v;
  endfunction

  function automatic logic [MW-1:0] mul_lane(input logic [KW-1:0] c, input logic [PW-1:0] p);
    logic signed [MW-1:0] a;
    logic signed [MW-1:0] b;
    a = $signed(c);
    b = $signed(p);
    return a * b;
  endfunction

  function automatic logic [SW-1:0] sum4(input logic [MW-1:0] m0, input logic [MW-1:0] m1,
                                         input logic [MW-1:0] m2, input logic [KW-1:0] c3);
    logic signed [SW-1:0] a0, a1, a2, a3;
    a0 = $signed(m0);
    a1 = $signed(m1);
    a2 = $signed(m2);
    a3 = $signed(c3);
    return a0 + a1 + a2 + (a3 <<< bpsr_pkg::FRAC_BITS);
  endfunction

  function automatic logic [SW-1:0] mag(input logic [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : v;
  endfunction

  function automatic logic div_bit(input logic [SW-1:0] r, input logic n, input logic [SW-1:0] d);
    return {r, n} >= {1'b0, d};
  endfunction

  function automatic logic [SW-1:0] div_rem(input logic [SW-1:0] r, input logic n,
                                            input logic [SW-1:0] d);
    logic [SW:0] t;
    t = {r, n};
    if (t >= {1'b0, d}) begin
      return SW'(t - {1'b0, d});
    end
    return t[SW-1:0];
  endfunction

  function automatic logic [CW:0] clamp(input logic [CW-1:0] q, input logic ovf, input logic neg);
    logic [CW-1:0] maxp;
    logic [CW-1:0] minn;
    maxp = {1'b0, {(CW-1){1'b1}}};
    minn = {1'b1, {(CW-1){1'b0}}};
    if (neg) begin
      if (ovf || (q[CW-1] && (|q[CW-2:0]))) return {1'b1, minn};
      return {1'b0, CW'(-q)};
    end
    if (ovf || q[CW-1]) return {1'b1, maxp};
    return {1'b0, q};
  endfunction

  logic [DW-1:0] mrow [0:3];
  logic          adv;

  assign pready = 1'b1;
  assign adv    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) mrow[r] <= ident_row(r);
    end else if (psel && penable && pwrite) begin
      case (bpsr_pkg::reg_idx_t'(paddr[4:3]))
        bpsr_pkg::REG_ROW_ZERO:  mrow[0] <= pwdata;
        bpsr_pkg::REG_ROW_ONE:   mrow[1] <= pwdata;
        bpsr_pkg::REG_ROW_TWO:   mrow[2] <= pwdata;
        bpsr_pkg::REG_ROW_THREE: mrow[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bpsr_pkg::reg_idx_t'(paddr[4:3]))
      bpsr_pkg::REG_ROW_ZERO:  prdata = mrow[0];
      bpsr_pkg::REG_ROW_ONE:   prdata = mrow[1];
      bpsr_pkg::REG_ROW_TWO:   prdata = mrow[2];
      bpsr_pkg::REG_ROW_THREE: prdata = mrow[3];
      default:                 prdata = '0;
    endcase
  end

  // box holding register and corner sequencer
  logic            box_valid;
  logic [XW-1:0]   cnt;
  logic [CW-1:0]   bc [0:2];
  logic [CW-3:0]   bh [0:2];
  logic            s_acc;

  assign s_tready = !box_valid || (adv && cnt == LAST_CORNER);
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
      cnt       <= '0;
    end else if (s_acc) begin
      box_valid <= 1'b1;
      cnt       <= '0;
    end else if (adv && box_valid) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_CORNER) box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      bc[0] <= s_tdata[0 +: CW];
      bc[1] <= s_tdata[CW +: CW];
      bc[2] <= s_tdata[2*CW +: CW];
      bh[0] <= s_tdata[3*CW + 1 +: CW-2];
      bh[1] <= s_tdata[4*CW     +: CW-2];
      bh[2] <= s_tdata[5*CW - 1 +: CW-2];
    end
  end

  // corner stage
  logic          a_valid;
  logic          a_first, a_last;
  logic [PW-1:0] pa [0:2];
  logic [2:0]    a_plus;

  assign a_plus = {cnt[1], cnt[2], cnt[0]};

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= box_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_first <= cnt == '0;
      a_last  <= cnt == LAST_CORNER;
      for (int k = 0; k < 3; k++) begin
        if (a_plus[k]) pa[k] <= {bc[k][CW-1], bc[k]} + {3'b000, bh[k]};
        else           pa[k] <= {bc[k][CW-1], bc[k]} - {3'b000, bh[k]};
      end
    end
  end

  // multiply stage
  logic          b_valid, b_first, b_last;
  logic [MW-1:0] mx [0:2];
  logic [MW-1:0] my [0:2];
  logic [MW-1:0] mw [0:2];

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (adv) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_first <= a_first;
      b_last  <= a_last;
      for (int l = 0; l < 3; l++) begin
        mx[l] <= mul_lane(mrow[0][l*KW +: KW], pa[l]);
        my[l] <= mul_lane(mrow[1][l*KW +: KW], pa[l]);
        mw[l] <= mul_lane(mrow[3][l*KW +: KW], pa[l]);
      end
    end
  end

  // sum stage
  logic          c_valid, c_first, c_last;
  logic [SW-1:0] sx, sy, sw;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (adv) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_first <= b_first;
      c_last  <= b_last;
      sx <= sum4(mx[0], mx[1], mx[2], mrow[0][3*KW +: KW]);
      sy <= sum4(my[0], my[1], my[2], mrow[1][3*KW +: KW]);
      sw <= sum4(mw[0], mw[1], mw[2], mrow[3][3*KW +: KW]);
    end
  end

  // magnitude stage
  logic          d_valid, d_first, d_last, d_negx, d_negy, d_zw;
  logic [SW-1:0] ax, ay, aw;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (adv) d_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_first <= c_first;
      d_last  <= c_last;
      d_negx  <= sx[SW-1] ^ sw[SW-1];
      d_negy  <= sy[SW-1] ^ sw[SW-1];
      d_zw    <= sw == '0;
      ax <= mag(sx);
      ay <= mag(sy);
      aw <= mag(sw);
    end
  end

  // divider pipeline: entry stage checks overflow, then one quotient bit per stage
  logic [NW-1:0] numx, numy;
  logic [HW-1:0] hx, hy;

  assign numx = {ax, {bpsr_pkg::FRAC_BITS{1'b0}}};
  assign numy = {ay, {bpsr_pkg::FRAC_BITS{1'b0}}};
  assign hx   = numx[NW-1:CW];
  assign hy   = numy[NW-1:CW];

  logic                   dv   [0:CW];
  bpsr_pkg::corner_meta_t dm   [0:CW];
  logic [SW-1:0]          den  [0:CW];
  logic [SW-1:0]          remx [0:CW];
  logic [SW-1:0]          remy [0:CW];
  logic [CW-1:0]          nlx  [0:CW];
  logic [CW-1:0]          nly  [0:CW];
  logic [CW-1:0]          qx   [0:CW];
  logic [CW-1:0]          qy   [0:CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CW; i++) dv[i] <= 1'b0;
    end else if (adv) begin
      dv[0] <= d_valid;
      for (int i = 1; i <= CW; i++) dv[i] <= dv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dm[0].first <= d_first;
      dm[0].last  <= d_last;
      dm[0].zw    <= d_zw;
      dm[0].negx  <= d_negx;
      dm[0].negy  <= d_negy;
      dm[0].ovfx  <= SW'(hx) >= aw;
      dm[0].ovfy  <= SW'(hy) >= aw;
      den[0]  <= aw;
      remx[0] <= SW'(hx);
      remy[0] <= SW'(hy);
      nlx[0]  <= numx[CW-1:0];
      nly[0]  <= numy[CW-1:0];
      qx[0]   <= '0;
      qy[0]   <= '0;
      for (int i = 1; i <= CW; i++) begin
        dm[i]   <= dm[i-1];
        den[i]  <= den[i-1];
        remx[i] <= div_rem(remx[i-1], nlx[i-1][CW-1], den[i-1]);
        remy[i] <= div_rem(remy[i-1], nly[i-1][CW-1], den[i-1]);
        qx[i]   <= {qx[i-1][CW-2:0], div_bit(remx[i-1], nlx[i-1][CW-1], den[i-1])};
        qy[i]   <= {qy[i-1][CW-2:0], div_bit(remy[i-1], nly[i-1][CW-1], den[i-1])};
        nlx[i]  <= nlx[i-1] << 1;
        nly[i]  <= nly[i-1] << 1;
      end
    end
  end

  // clamp stage
  logic          f_valid, f_first, f_last, f_zw, f_sat;
  logic [CW-1:0] fx, fy;
  logic [CW:0]   cx, cy;

  assign cx = clamp(qx[CW], dm[CW].ovfx, dm[CW].negx);
  assign cy = clamp(qy[CW], dm[CW].ovfy, dm[CW].negy);

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (adv) f_valid <= dv[CW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_first <= dm[CW].first;
      f_last  <= dm[CW].last;
      f_zw    <= dm[CW].zw;
      f_sat   <= !dm[CW].zw && (cx[CW] || cy[CW]);
      fx      <= cx[CW-1:0];
      fy      <= cy[CW-1:0];
    end
  end

  // bounding accumulation
  logic          acc_any, acc_zw, acc_sat;
  logic [CW-1:0] acc_l, acc_r, acc_t, acc_b;
  logic          base_any, base_zw, base_sat;
  logic [CW-1:0] base_l, base_r, base_t, base_b;
  logic          any_next, zw_next, sat_next;
  logic [CW-1:0] l_next, r_next, t_next, b_next;

  always_comb begin
    base_any = f_first ? 1'b0 : acc_any;
    base_zw  = f_first ? 1'b0 : acc_zw;
    base_sat = f_first ? 1'b0 : acc_sat;
    base_l   = f_first ? '0 : acc_l;
    base_r   = f_first ? '0 : acc_r;
    base_t   = f_first ? '0 : acc_t;
    base_b   = f_first ? '0 : acc_b;
    any_next = base_any | !f_zw;
    zw_next  = base_zw | f_zw;
    sat_next = base_sat | f_sat;
    l_next   = base_l;
    r_next   = base_r;
    t_next   = base_t;
    b_next   = base_b;
    if (!f_zw) begin
      if (!base_any) begin
        l_next = fx;
        r_next = fx;
        t_next = fy;
        b_next = fy;
      end else begin
        if ($signed(fx) < $signed(base_l)) l_next = fx;
        if ($signed(fx) > $signed(base_r)) r_next = fx;
        if ($signed(fy) > $signed(base_t)) t_next = fy;
        if ($signed(fy) < $signed(base_b)) b_next = fy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f_valid) begin
      acc_any <= any_next;
      acc_zw  <= zw_next;
      acc_sat <= sat_next;
      acc_l   <= l_next;
      acc_r   <= r_next;
      acc_t   <= t_next;
      acc_b   <= b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && f_valid && f_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f_valid && f_last) begin
      m_tdata <= OW'({b_next, t_next, r_next, l_next});
      m_tuser <= {sat_next, !any_next, zw_next};
    end
  end

endmodule
